// ----- rtl/core/nnis_pkg.sv -----
// nnis_pkg: shared types and constants for the nearest neighbour image scaler
// no dependencies; imported by nnis_store, nearest_neighbour_image_scaler and the testbench

package nnis_pkg;

    // configuration register width and the product width of the shared multiplier
    localparam int CFG_W  = 9;
    localparam int PROD_W = 2 * CFG_W;
    localparam int PIX_W  = 8;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EMIT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_WR,
        ST_EM_FIX,
        ST_ROW_MUL,
        ST_ROW_DIV,
        ST_COL_MUL,
        ST_COL_DIV,
        ST_ADDR,
        ST_READ,
        ST_RESP
    } seq_state_t;

endpackage

// ----- rtl/core/nnis_store.sv -----
// nnis_store: frame store, one write port and one registered read port
// depends on nnis_pkg for the pixel width

module nnis_store
    import nnis_pkg::*;
#(
    parameter int DEPTH = 65536
)(
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [PIX_W-1:0]          wdata,
    input  logic                      re,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [PIX_W-1:0]          rdata
);

    logic [PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/nearest_neighbour_image_scaler.sv -----
// nearest_neighbour_image_scaler: top level, sequencer, shared multiplier and divide step
// depends on nnis_pkg and nnis_store
//
// channel   direction  handshake                  payload
// -------   ---------  -------------------------  ---------------------------
// request   in         start high, busy low       req_type, pixel_in
// result    out        done strobe, one cycle     pixel_out, frame_last
// config    in/out     apb write at access phase  paddr, pwdata / prdata
//
// a load beat runs from accept through area product and store write, then back to idle
// an emit beat runs range fix, then a multiply and CNT_W restoring divide steps each for row and
// column, then address product, store read and result
// busy is high from accept until the sequencer is back in idle
// the receiver cannot stall: done, pixel_out and frame_last are valid for one cycle
// reset clears the counters and sets all sizes to MAX_DIM; the store has no reset

module nearest_neighbour_image_scaler
    import nnis_pkg::*;
#(
    parameter int MAX_DIM = 256
)(
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // request channel
    input  logic              start,
    output logic              busy,
    input  logic              req_type,
    input  logic [PIX_W-1:0]  pixel_in,
    // result channel
    output logic              done,
    output logic [PIX_W-1:0]  pixel_out,
    output logic              frame_last
);

    // sizes never exceed what the 9-bit registers can hold
    localparam int EFF_DIM = (MAX_DIM < 511) ? MAX_DIM : 511;
    localparam int CNT_W   = $clog2(EFF_DIM);
    localparam int DEPTH   = EFF_DIM * EFF_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int STEP_W  = (CNT_W > 1) ? $clog2(CNT_W) : 1;
    localparam int SH_W    = PROD_W + 1;
    localparam logic [CFG_W-1:0]  DIM_RST   = CFG_W'(EFF_DIM);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CNT_W - 1);

    // ---------------------------------------------------------------
    // configuration registers, stored already clamped
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] src_width_reg;
    logic [CFG_W-1:0] src_height_reg;
    logic [CFG_W-1:0] dst_width_reg;
    logic [CFG_W-1:0] dst_height_reg;
    logic             cfg_wr;
    logic [CFG_W-1:0] cfg_val;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0)
        begin
            r = CFG_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            r = DIM_RST;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_val = clamp_dim(pwdata[CFG_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= DIM_RST;
            src_height_reg <= DIM_RST;
            dst_width_reg  <= DIM_RST;
            dst_height_reg <= DIM_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_SRC_WIDTH:  src_width_reg  <= cfg_val;
                REG_SRC_HEIGHT: src_height_reg <= cfg_val;
                REG_DST_WIDTH:  dst_width_reg  <= cfg_val;
                REG_DST_HEIGHT: dst_height_reg <= cfg_val;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SRC_WIDTH:  prdata = APB_DW'(src_width_reg);
            REG_SRC_HEIGHT: prdata = APB_DW'(src_height_reg);
            REG_DST_WIDTH:  prdata = APB_DW'(dst_width_reg);
            REG_DST_HEIGHT: prdata = APB_DW'(dst_height_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer and datapath registers
    // ---------------------------------------------------------------
    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] load_index_reg, load_index_next;
    logic [CNT_W-1:0]  out_row_reg, out_row_next;
    logic [CNT_W-1:0]  out_col_reg, out_col_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  sr_reg, sr_next;
    logic [CNT_W-1:0]  sc_reg, sc_next;

    // shared multiplier
    logic [CFG_W-1:0]  mul_a;
    logic [CFG_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;

    // shared restoring divide step
    logic [CFG_W-1:0]  div_d;
    logic [SH_W-1:0]   div_shift;
    logic              div_fits;
    logic [PROD_W-1:0] div_rem;
    logic [CNT_W-1:0]  div_quot;

    // store port
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic              st_re;
    logic [ADDR_W-1:0] st_raddr;
    logic [PIX_W-1:0]  st_rdata;

    // counter helpers
    logic [CFG_W-1:0]  row_ext;
    logic [CFG_W-1:0]  col_ext;
    logic [CFG_W-1:0]  row_inc;
    logic [CFG_W-1:0]  col_inc;
    logic [ADDR_W-1:0] ld_idx;
    logic [PROD_W-1:0] ld_inc;

    assign row_ext = CFG_W'(out_row_reg);
    assign col_ext = CFG_W'(out_col_reg);
    assign row_inc = row_ext + CFG_W'(1);
    assign col_inc = col_ext + CFG_W'(1);

    // prod_reg holds the source area during a load
    assign ld_idx = (PROD_W'(load_index_reg) >= prod_reg) ? '0 : load_index_reg;
    assign ld_inc = PROD_W'(ld_idx) + PROD_W'(1);

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign div_d     = (state_reg == ST_COL_DIV) ? dst_width_reg : dst_height_reg;
    assign div_shift = SH_W'(div_d) << step_reg;
    assign div_fits  = SH_W'(rem_reg) >= div_shift;
    assign div_rem   = div_fits ? (rem_reg - PROD_W'(div_shift)) : rem_reg;
    assign div_quot  = div_fits ? (quot_reg | (CNT_W'(1) << step_reg)) : quot_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (req_type == REQ_LOAD) ? ST_LD_MUL : ST_EM_FIX;
                end
            end
            ST_LD_MUL:  state_next = ST_LD_WR;
            ST_LD_WR:   state_next = ST_IDLE;
            ST_EM_FIX:  state_next = ST_ROW_MUL;
            ST_ROW_MUL: state_next = ST_ROW_DIV;
            ST_ROW_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_COL_MUL;
                end
            end
            ST_COL_MUL: state_next = ST_COL_DIV;
            ST_COL_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:    state_next = ST_READ;
            ST_READ:    state_next = ST_RESP;
            ST_RESP:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath controls and next values
    always_comb
    begin
        load_index_next = load_index_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        pix_next        = pix_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        step_next       = step_reg;
        sr_next         = sr_reg;
        sc_next         = sc_reg;
        mul_a           = '0;
        mul_b           = '0;
        st_we           = 1'b0;
        st_waddr        = ld_idx;
        st_re           = 1'b0;
        st_raddr        = ADDR_W'(prod_reg + PROD_W'(sc_reg));
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pix_next = pixel_in;
                end
            end
            ST_LD_MUL:
            begin
                mul_a     = src_width_reg;
                mul_b     = src_height_reg;
                prod_next = mul_p;
            end
            ST_LD_WR:
            begin
                st_we = 1'b1;
                load_index_next = (ld_inc >= prod_reg) ? '0 : ADDR_W'(ld_inc);
            end
            ST_EM_FIX:
            begin
                // counters left out of range by a size change restart at zero
                if (row_ext >= dst_height_reg)
                begin
                    out_row_next = '0;
                end
                if (col_ext >= dst_width_reg)
                begin
                    out_col_next = '0;
                end
            end
            ST_ROW_MUL:
            begin
                mul_a     = row_ext;
                mul_b     = src_height_reg;
                rem_next  = mul_p;
                quot_next = '0;
                step_next = STEP_LAST;
            end
            ST_ROW_DIV:
            begin
                rem_next  = div_rem;
                quot_next = div_quot;
                if (step_reg != '0)
                begin
                    step_next = step_reg - STEP_W'(1);
                end
                else
                begin
                    sr_next = div_quot;
                end
            end
            ST_COL_MUL:
            begin
                mul_a     = col_ext;
                mul_b     = src_width_reg;
                rem_next  = mul_p;
                quot_next = '0;
                step_next = STEP_LAST;
            end
            ST_COL_DIV:
            begin
                rem_next  = div_rem;
                quot_next = div_quot;
                if (step_reg != '0)
                begin
                    step_next = step_reg - STEP_W'(1);
                end
                else
                begin
                    sc_next = div_quot;
                end
            end
            ST_ADDR:
            begin
                mul_a     = CFG_W'(sr_reg);
                mul_b     = src_width_reg;
                prod_next = mul_p;
            end
            ST_READ:
            begin
                st_re = 1'b1;
            end
            ST_RESP:
            begin
                // raster advance with wrap at the end of the frame
                if (col_inc >= dst_width_reg)
                begin
                    out_col_next = '0;
                    out_row_next = (row_inc >= dst_height_reg) ? '0 : CNT_W'(row_inc);
                end
                else
                begin
                    out_col_next = CNT_W'(col_inc);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_index_reg <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_index_reg <= load_index_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
        sr_reg   <= sr_next;
        sc_reg   <= sc_next;
    end

    nnis_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (pix_reg),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // result beat
    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_RESP);
    assign pixel_out  = st_rdata;
    assign frame_last = (row_ext == dst_height_reg - CFG_W'(1)) &&
                        (col_ext == dst_width_reg - CFG_W'(1));

endmodule

// ----- tb/sv/tb_nearest_neighbour_image_scaler.sv -----
`timescale 1ns / 100ps
// tb_nearest_neighbour_image_scaler: self-checking bench for the nearest neighbour scaler
// depends on nnis_pkg and the nearest_neighbour_image_scaler top level
// a tracker class mirrors the frame store and the load/output counters and checks each pixel

module tb_nearest_neighbour_image_scaler;
    import nnis_pkg::*;

    localparam int MAX_DIM       = 256;
    // margin after the last beat, longer than a whole emit beat at MAX_DIM 256
    localparam int SETTLE_CYCLES = 30;
    // no accept and no result for this long means the block is stuck
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 12;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last;
    } scaled_pixel_t;

    // mirror of the scaler: sizes, counters, frame store and the pixels still owed
    class scaled_pixel_tracker;
        int unsigned      src_w    = MAX_DIM;
        int unsigned      src_h    = MAX_DIM;
        int unsigned      dst_w    = MAX_DIM;
        int unsigned      dst_h    = MAX_DIM;
        int unsigned      load_pos = 0;
        int unsigned      out_r    = 0;
        int unsigned      out_c    = 0;
        logic [PIX_W-1:0] frame [MAX_DIM*MAX_DIM];
        bit               written [MAX_DIM*MAX_DIM];
        scaled_pixel_t    pending_pixels [$];
        int               errors   = 0;

        // zero acts as one, anything past the maximum acts as the maximum
        function int unsigned eff_dim(logic [CFG_W-1:0] v);
            if (v == '0)
                return 1;
            if (v > MAX_DIM)
                return MAX_DIM;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_SRC_WIDTH:  src_w = eff_dim(value[CFG_W-1:0]);
                REG_SRC_HEIGHT: src_h = eff_dim(value[CFG_W-1:0]);
                REG_DST_WIDTH:  dst_w = eff_dim(value[CFG_W-1:0]);
                default:        dst_h = eff_dim(value[CFG_W-1:0]);
            endcase
        endfunction

        // store address the next emit reads, counters restarted if out of range
        function int unsigned emit_src_addr();
            int unsigned r;
            int unsigned c;
            r = (out_r >= dst_h) ? 0 : out_r;
            c = (out_c >= dst_w) ? 0 : out_c;
            return ((r * src_h) / dst_h) * src_w + (c * src_w) / dst_w;
        endfunction

        function bit next_read_written();
            return written[emit_src_addr()];
        endfunction

        function void accept_beat(logic req, logic [PIX_W-1:0] pix);
            scaled_pixel_t px;
            int unsigned   area;
            int unsigned   addr;
            if (req == REQ_LOAD) begin
                area = src_w * src_h;
                if (load_pos >= area)
                    load_pos = 0;
                frame[load_pos]   = pix;
                written[load_pos] = 1'b1;
                load_pos++;
                if (load_pos >= area)
                    load_pos = 0;
            end
            else begin
                addr = emit_src_addr();
                if (out_r >= dst_h)
                    out_r = 0;
                if (out_c >= dst_w)
                    out_c = 0;
                px.pix  = frame[addr];
                px.last = (out_r == dst_h - 1) && (out_c == dst_w - 1);
                pending_pixels.push_back(px);
                out_c++;
                if (out_c >= dst_w) begin
                    out_c = 0;
                    out_r++;
                    if (out_r >= dst_h)
                        out_r = 0;
                end
            end
        endfunction

        function void check_pixel(logic [PIX_W-1:0] pix, logic last);
            scaled_pixel_t px;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, actual pixel_out %0d frame_last %0b",
                         $time, pix, last);
            end
            else begin
                px = pending_pixels.pop_front();
                if (pix !== px.pix) begin
                    errors++;
                    $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                             $time, px.pix, pix);
                end
                if (last !== px.last) begin
                    errors++;
                    $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                             $time, px.last, last);
                end
            end
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // apb side
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // request and result channels
    logic              start    = 1'b0;
    logic              busy;
    logic              req_type = REQ_LOAD;
    logic [PIX_W-1:0]  pixel_in = '0;
    logic              done;
    logic [PIX_W-1:0]  pixel_out;
    logic              frame_last;

    scaled_pixel_tracker tracker;

    nearest_neighbour_image_scaler #(
        .MAX_DIM    (MAX_DIM)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .pixel_in   (pixel_in),
        .done       (done),
        .pixel_out  (pixel_out),
        .frame_last (frame_last)
    );

    always #5 clk = ~clk;

    // result beats last one cycle and cannot be held off, so check every strobe
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_pixel(pixel_out, frame_last);
    end

    // mostly back to back or short gaps, now and then a long one; calm phases are always back to back
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // register value with random upper bits, which the block drops
    function automatic logic [APB_DW-1:0] pick_dim();
        logic [APB_DW-1:0] v;
        int unsigned       r;
        v = $urandom;
        r = $urandom_range(0, 99);
        if (r < 6)
            v[CFG_W-1:0] = '0;
        else if (r < 12)
            v[CFG_W-1:0] = CFG_W'($urandom_range(257, 511));
        else if (r < 18)
            v[CFG_W-1:0] = CFG_W'(MAX_DIM);
        else if (r < 35)
            v[CFG_W-1:0] = CFG_W'(1);
        else
            v[CFG_W-1:0] = CFG_W'($urandom_range(2, 16));
        return v;
    endfunction

    // one request beat; start stays high afterwards so the next beat can follow directly
    task automatic send_item(input logic req, input logic [PIX_W-1:0] pix, input int unsigned gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= req;
        pixel_in <= pix;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.accept_beat(req, pix);
    endtask

    // setup then access phase, idle cycle after so psel never toggles twice in a step
    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(idx, value);
        @(posedge clk);
    endtask

    // sender holds off until every owed pixel has come out
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // a load gives no result, so also wait for busy and a margin
    task automatic wait_until_idle();
        drain_results();
        while (busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sizes(input logic [APB_DW-1:0] sw, input logic [APB_DW-1:0] sh,
                               input logic [APB_DW-1:0] dw, input logic [APB_DW-1:0] dh);
        write_reg(REG_SRC_WIDTH,  sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH,  dw);
        write_reg(REG_DST_HEIGHT, dh);
    endtask

    // stuck detector
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("nearest_neighbour_image_scaler test failed");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned       n;
        int unsigned       emit_pct;
        bit                calm;
        logic [APB_DW-1:0] sw;
        logic [APB_DW-1:0] sh;
        logic [APB_DW-1:0] dw;
        logic [APB_DW-1:0] dh;
        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: extreme pixel values, emits read store entries 0 and 1
        send_item(REQ_LOAD, 8'h00, 0);
        send_item(REQ_LOAD, 8'hFF, 1);
        send_item(REQ_EMIT, 8'hFF, 0);
        send_item(REQ_EMIT, 8'h00, 2);

        // zero sizes act as one; load counter past the new area restarts,
        // output column left at 2 stays in range, frame_last on the fourth emit
        wait_until_idle();
        write_sizes(32'h0, 32'h0, 32'd3, 32'd2);
        send_item(REQ_LOAD, 8'hA5, 0);
        repeat (6)
            send_item(REQ_EMIT, 8'($urandom_range(0, 255)), pick_gap(1'b0));

        // oversized values act as the maximum, upper bits of pwdata ignored,
        // 1x1 output flags every pixel as last, stale column restarts
        wait_until_idle();
        write_sizes(32'h0000_01FF, 32'hFFFF_FFFF, 32'hFFFF_FE01, 32'd1);
        send_item(REQ_EMIT, 8'h81, 0);
        send_item(REQ_LOAD, 8'h5A, 0);
        send_item(REQ_EMIT, 8'h7E, 3);

        // random phases: new sizes each time, counters carried over from the last phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_until_idle();
            n        = $urandom_range(30, 45);
            emit_pct = $urandom_range(30, 80);
            calm     = ($urandom_range(0, 3) == 0);
            if (p == 0) begin
                sw = 32'd1; sh = 32'd1; dw = 32'd1; dh = 32'd1;
            end
            else if (p == 1) begin
                // full-width output line so the last pixel lands at column 255
                sw = 32'd1; sh = 32'd1; dw = MAX_DIM; dh = 32'd1;
                n        = 270;
                emit_pct = 97;
            end
            else begin
                sw = pick_dim();
                sh = pick_dim();
                dw = pick_dim();
                dh = pick_dim();
                // keep the areas small so frames fill and finish quickly
                if (tracker.eff_dim(sw[CFG_W-1:0]) * tracker.eff_dim(sh[CFG_W-1:0]) > 256)
                    sh = $urandom_range(1, 4);
                if (tracker.eff_dim(dw[CFG_W-1:0]) * tracker.eff_dim(dh[CFG_W-1:0]) > 256)
                    dh = $urandom_range(1, 4);
            end
            write_sizes(sw, sh, dw, dh);
            for (int i = 0; i < n; i++) begin
                if ((p == 2 && i == n / 2) || $urandom_range(0, 39) == 0)
                    drain_results();
                // an emit whose source pixel was never loaded becomes a load
                if ($urandom_range(0, 99) < emit_pct && tracker.next_read_written())
                    send_item(REQ_EMIT, 8'($urandom_range(0, 255)), pick_gap(calm));
                else
                    send_item(REQ_LOAD, 8'($urandom_range(0, 255)), pick_gap(calm));
            end
        end

        wait_until_idle();
        if (tracker.errors == 0 && tracker.pending_pixels.size() == 0)
            $display("nearest_neighbour_image_scaler test passed");
        else
            $display("nearest_neighbour_image_scaler test failed");
        $finish;
    end

endmodule
